// ===== rtl/iss_pkg.sv =====
package iss_pkg;

   localparam int CAPACITY     = 512;
   localparam int VALUE_W      = 32;
   localparam int REQ_INDEX_W  = 9;
   localparam int RSP_COUNT_W  = 10;
   localparam int INDEX_W      = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W      = $clog2(CAPACITY + 1);
   localparam int WIDE_W       = (REQ_INDEX_W > COUNT_W) ? REQ_INDEX_W : COUNT_W;

   localparam int FAN          = 8;
   localparam int LVL1_N       = (CAPACITY + FAN - 1) / FAN;
   localparam int LVL2_N       = (LVL1_N + FAN - 1) / FAN;
   localparam int LVL3_N       = (LVL2_N + FAN - 1) / FAN;
   localparam int TAG_DEPTH    = 4;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_READ   = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic                       ins_en;
      logic signed [VALUE_W-1:0]  ins_value;
      logic [COUNT_W-1:0]         count;
      logic [WIDE_W-1:0]          rd_index;
   } cell_bcast_type;

   typedef struct packed {
      logic               valid;
      logic               read_ok;
      logic [COUNT_W-1:0] count;
      status_type         status;
   } tag_type;

endpackage

// ===== rtl/iss_cell.sv =====
module iss_cell (
   input  logic                                  clock,
   input  iss_pkg::cell_bcast_type               bcast,
   input  logic [iss_pkg::INDEX_W-1:0]           cell_index,
   input  logic signed [iss_pkg::VALUE_W-1:0]    left_value,
   input  logic                                  left_greater,
   output logic signed [iss_pkg::VALUE_W-1:0]    value,
   output logic                                  greater,
   output logic [iss_pkg::VALUE_W-1:0]           read_tap
);
   import iss_pkg::*;

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      occupied;

   assign occupied = COUNT_W'(cell_index) < bcast.count;
   assign greater  = !occupied || (value_ff > bcast.ins_value);

   always_comb begin
      value_in = value_ff;
      if (bcast.ins_en && greater) begin
         value_in = left_greater ? left_value : bcast.ins_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value    = value_ff;
   assign read_tap = (bcast.rd_index == WIDE_W'(cell_index)) ? value_ff : '0;

endmodule

// ===== rtl/incremental_sorted_store.sv =====
// Sorted store built as a row of compare-and-shift cells, one cell per entry.
// Each insert or read ends in one rsp_strobe. Throughput: one request per cycle; busy
// stays low. An insert shifts the empty cells and those with greater values on the
// accept edge; a read gathers its entry through a three-level registered OR tree.
// Reset clears the count and the result pipeline; cell contents stay undefined.
// The receiver cannot stall: each result is shown for exactly one cycle.
module incremental_sorted_store (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_opcode,
   input  logic signed [iss_pkg::VALUE_W-1:0]    req_new_value,
   input  logic [iss_pkg::REQ_INDEX_W-1:0]       req_read_index,
   output logic                                  rsp_strobe,
   output logic signed [iss_pkg::VALUE_W-1:0]    rsp_read_value,
   output logic [iss_pkg::RSP_COUNT_W-1:0]       rsp_stored_count,
   output logic [1:0]                            rsp_status
);
   import iss_pkg::*;

   logic                      accept;
   logic                      full;
   logic                      is_read;
   logic                      in_range;
   logic [WIDE_W-1:0]         req_index_wide;
   cell_bcast_type            bcast;

   logic [COUNT_W-1:0]        count_ff;
   logic [COUNT_W-1:0]        count_in;
   logic [WIDE_W-1:0]         rd_index_ff;
   tag_type                   tag_ff [TAG_DEPTH];
   tag_type                   tag_in;

   logic signed [VALUE_W-1:0] cell_value   [CAPACITY];
   logic                      cell_greater [CAPACITY];
   logic [VALUE_W-1:0]        cell_tap     [CAPACITY];

   logic [VALUE_W-1:0]        lvl1_in [LVL1_N];
   logic [VALUE_W-1:0]        lvl1_ff [LVL1_N];
   logic [VALUE_W-1:0]        lvl2_in [LVL2_N];
   logic [VALUE_W-1:0]        lvl2_ff [LVL2_N];
   logic [VALUE_W-1:0]        lvl3_in [LVL3_N];
   logic [VALUE_W-1:0]        lvl3_ff [LVL3_N];
   logic [VALUE_W-1:0]        root;

   logic                      rsp_strobe_ff;
   logic [VALUE_W-1:0]        rsp_value_ff;
   logic [RSP_COUNT_W-1:0]    rsp_count_ff;
   status_type                rsp_status_ff;

   assign busy           = 1'b0;
   assign accept         = start && !busy;
   assign is_read        = (opcode_type'(req_opcode) == OP_READ);
   assign full           = (count_ff == COUNT_W'(CAPACITY));
   assign req_index_wide = WIDE_W'(req_read_index);
   assign in_range       = req_index_wide < WIDE_W'(count_ff);

   assign bcast.ins_en    = accept && !is_read && !full;
   assign bcast.ins_value = req_new_value;
   assign bcast.count     = count_ff;
   assign bcast.rd_index  = rd_index_ff;

   assign count_in = bcast.ins_en ? count_ff + COUNT_W'(1) : count_ff;

   always_comb begin
      tag_in.valid   = accept;
      tag_in.read_ok = is_read && in_range;
      tag_in.count   = count_in;
      tag_in.status  = ST_OK;
      if (is_read && !in_range) begin
         tag_in.status = ST_RANGE;
      end else if (!is_read && full) begin
         tag_in.status = ST_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < TAG_DEPTH; i++) begin
            tag_ff[i] <= '0;
         end
      end else begin
         count_ff  <= count_in;
         tag_ff[0] <= tag_in;
         for (int i = 1; i < TAG_DEPTH; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_index_ff <= req_index_wide;
      end
   end

   genvar c, g, j;
   generate
      for (c = 0; c < CAPACITY; c++) begin : g_cell
         if (c == 0) begin : g_head
            iss_cell u_cell (
               .clock        (clock),
               .bcast        (bcast),
               .cell_index   (INDEX_W'(c)),
               .left_value   ('0),
               .left_greater (1'b0),
               .value        (cell_value[c]),
               .greater      (cell_greater[c]),
               .read_tap     (cell_tap[c])
            );
         end else begin : g_body
            iss_cell u_cell (
               .clock        (clock),
               .bcast        (bcast),
               .cell_index   (INDEX_W'(c)),
               .left_value   (cell_value[c-1]),
               .left_greater (cell_greater[c-1]),
               .value        (cell_value[c]),
               .greater      (cell_greater[c]),
               .read_tap     (cell_tap[c])
            );
         end
      end

      for (g = 0; g < LVL1_N; g++) begin : g_lvl1
         logic [VALUE_W-1:0] part [FAN];
         for (j = 0; j < FAN; j++) begin : g_leg
            if (g * FAN + j < CAPACITY) begin : g_use
               assign part[j] = cell_tap[g*FAN+j];
            end else begin : g_pad
               assign part[j] = '0;
            end
         end
         always_comb begin
            lvl1_in[g] = '0;
            for (int k = 0; k < FAN; k++) begin
               lvl1_in[g] = lvl1_in[g] | part[k];
            end
         end
      end

      for (g = 0; g < LVL2_N; g++) begin : g_lvl2
         logic [VALUE_W-1:0] part [FAN];
         for (j = 0; j < FAN; j++) begin : g_leg
            if (g * FAN + j < LVL1_N) begin : g_use
               assign part[j] = lvl1_ff[g*FAN+j];
            end else begin : g_pad
               assign part[j] = '0;
            end
         end
         always_comb begin
            lvl2_in[g] = '0;
            for (int k = 0; k < FAN; k++) begin
               lvl2_in[g] = lvl2_in[g] | part[k];
            end
         end
      end

      for (g = 0; g < LVL3_N; g++) begin : g_lvl3
         logic [VALUE_W-1:0] part [FAN];
         for (j = 0; j < FAN; j++) begin : g_leg
            if (g * FAN + j < LVL2_N) begin : g_use
               assign part[j] = lvl2_ff[g*FAN+j];
            end else begin : g_pad
               assign part[j] = '0;
            end
         end
         always_comb begin
            lvl3_in[g] = '0;
            for (int k = 0; k < FAN; k++) begin
               lvl3_in[g] = lvl3_in[g] | part[k];
            end
         end
      end
   endgenerate

   always_comb begin
      root = '0;
      for (int k = 0; k < LVL3_N; k++) begin
         root = root | lvl3_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      lvl1_ff <= lvl1_in;
      lvl2_ff <= lvl2_in;
      lvl3_ff <= lvl3_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= tag_ff[TAG_DEPTH-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= tag_ff[TAG_DEPTH-1].read_ok ? root : '0;
      rsp_count_ff  <= RSP_COUNT_W'(tag_ff[TAG_DEPTH-1].count);
      rsp_status_ff <= tag_ff[TAG_DEPTH-1].status;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_read_value   = rsp_value_ff;
   assign rsp_stored_count = rsp_count_ff;
   assign rsp_status       = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      bcast.ins_en |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("insert did not advance count");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |-> rsp_read_value == '0)
      else $error("error result carries nonzero value");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_read && full) |=> $stable(count_ff))
      else $error("insert into full store changed count");

endmodule
